// File: src/pri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_pkg
// Shared types, widths and constants of the point rotate and isometric
// projection pipeline.
// ----------------------------------------------------------------------------
package pri_pkg;

   // Field widths
   localparam int POINT_W  = 16;
   localparam int COEF_W   = 16;
   localparam int OFFSET_W = 13;
   localparam int SCREEN_W = 18;

   // Fixed-point layout
   localparam int COEF_FRAC = 14;
   localparam int PROJ_FRAC = 30;

   // Coordinates inside the rotation chain, Q14 with headroom for growth
   localparam int COORD_W = 36;
   localparam int PROD_W  = COORD_W + COEF_W;
   localparam int SUM_W   = PROD_W + 1;

   // Projection datapath
   localparam int KCONST_W = 17;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PPROD_W  = DIFF_W + KCONST_W;
   localparam int PRJ_W    = PPROD_W + 1;
   localparam int Q_W      = PRJ_W - PROJ_FRAC;
   localparam int POS_W    = Q_W + 1;

   // Projection constants, unsigned Q16 held as positive signed values
   localparam logic signed [KCONST_W-1:0] K_HALF_SQRT2      = 17'sd46341;
   localparam logic signed [KCONST_W-1:0] K_SQRT_TWO_THIRDS = 17'sd53509;
   localparam logic signed [KCONST_W-1:0] K_INV_SQRT6       = 17'sd26755;

   // Screen bounds and output clamp
   localparam int SCREEN_WIDTH  = 1920;
   localparam int SCREEN_HEIGHT = 1080;
   localparam int OUT_MAX       = 131071;
   localparam int OUT_MIN       = -131072;

   // Configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      REG_COS_X    = 3'd0,
      REG_SIN_X    = 3'd1,
      REG_COS_Y    = 3'd2,
      REG_SIN_Y    = 3'd3,
      REG_COS_Z    = 3'd4,
      REG_SIN_Z    = 3'd5,
      REG_OFFSET_X = 3'd6,
      REG_OFFSET_Y = 3'd7
   } reg_addr_type;

   typedef logic signed [POINT_W-1:0]  point_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic signed [SCREEN_W-1:0] screen_type;
   typedef logic signed [COORD_W-1:0]  coord_type;

   typedef struct packed {
      coef_type cos_val;
      coef_type sin_val;
   } rot_coef_type;

   typedef struct packed {
      rot_coef_type rot_x;
      rot_coef_type rot_y;
      rot_coef_type rot_z;
      offset_type   offset_x;
      offset_type   offset_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      rot_x:    '{cos_val: 16'sd14189, sin_val: 16'sd8192},
      rot_y:    '{cos_val: 16'sd14189, sin_val: 16'sd8192},
      rot_z:    '{cos_val: 16'sd14189, sin_val: 16'sd8192},
      offset_x: 13'sd960,
      offset_y: 13'sd540
   };

endpackage

// File: src/pri_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_csr
// APB-style register file holding rotation coefficients and screen offsets.
// ----------------------------------------------------------------------------
module pri_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pri_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [pri_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [pri_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output pri_pkg::cfg_type                 cfg
);
   import pri_pkg::*;

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   reg_addr_type addr_idx;
   logic         wr_en;

   assign addr_idx   = reg_addr_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (addr_idx)
            REG_COS_X:    cfg_in.rot_x.cos_val = csr_pwdata[COEF_W-1:0];
            REG_SIN_X:    cfg_in.rot_x.sin_val = csr_pwdata[COEF_W-1:0];
            REG_COS_Y:    cfg_in.rot_y.cos_val = csr_pwdata[COEF_W-1:0];
            REG_SIN_Y:    cfg_in.rot_y.sin_val = csr_pwdata[COEF_W-1:0];
            REG_COS_Z:    cfg_in.rot_z.cos_val = csr_pwdata[COEF_W-1:0];
            REG_SIN_Z:    cfg_in.rot_z.sin_val = csr_pwdata[COEF_W-1:0];
            REG_OFFSET_X: cfg_in.offset_x      = csr_pwdata[OFFSET_W-1:0];
            REG_OFFSET_Y: cfg_in.offset_y      = csr_pwdata[OFFSET_W-1:0];
            default:      cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register, sign extended
   always_comb begin
      case (addr_idx)
         REG_COS_X:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_x.cos_val);
         REG_SIN_X:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_x.sin_val);
         REG_COS_Y:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_y.cos_val);
         REG_SIN_Y:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_y.sin_val);
         REG_COS_Z:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_z.cos_val);
         REG_SIN_Z:    csr_prdata = CSR_DATA_W'(cfg_ff.rot_z.sin_val);
         REG_OFFSET_X: csr_prdata = CSR_DATA_W'(cfg_ff.offset_x);
         REG_OFFSET_Y: csr_prdata = CSR_DATA_W'(cfg_ff.offset_y);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

// File: src/pri_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_rotate
// Two-stage planar rotation of Q14 coordinates: a multiply stage and an
// add-and-round stage. first = a*cos - b*sin, second = a*sin + b*cos, both
// rounded back to Q14; carry passes along untouched.
// ----------------------------------------------------------------------------
module pri_rotate (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pri_pkg::coord_type    in_a,
   input  pri_pkg::coord_type    in_b,
   input  pri_pkg::coord_type    in_carry,
   input  pri_pkg::rot_coef_type coef,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pri_pkg::coord_type    out_first,
   output pri_pkg::coord_type    out_second,
   output pri_pkg::coord_type    out_carry
);
   import pri_pkg::*;

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(2 ** (COEF_FRAC - 1));

   coef_type cos_val;
   coef_type sin_val;

   // Multiply stage
   logic                    mul_valid_ff;
   logic                    mul_ready;
   logic signed [PROD_W-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [PROD_W-1:0] ac_in, bs_in, as_in, bc_in;
   coord_type               mul_carry_ff;

   // Round stage
   logic                    rnd_valid_ff;
   logic                    rnd_ready;
   logic signed [SUM_W-1:0] first_sum, second_sum;
   logic signed [SUM_W-1:0] first_shift, second_shift;
   coord_type               first_in, second_in;
   coord_type               first_ff, second_ff, rnd_carry_ff;

   assign cos_val = coef.cos_val;
   assign sin_val = coef.sin_val;

   assign mul_ready = ~mul_valid_ff | rnd_ready;
   assign rnd_ready = ~rnd_valid_ff | out_ready;
   assign in_ready  = mul_ready;

   // Form the four partial products
   always_comb begin
      ac_in = in_a * cos_val;
      bs_in = in_b * sin_val;
      as_in = in_a * sin_val;
      bc_in = in_b * cos_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         ac_ff        <= ac_in;
         bs_ff        <= bs_in;
         as_ff        <= as_in;
         bc_ff        <= bc_in;
         mul_carry_ff <= in_carry;
      end
   end

   // Combine, add half an LSB and floor back to Q14
   always_comb begin
      first_sum    = SUM_W'(ac_ff) - SUM_W'(bs_ff) + ROUND_HALF;
      second_sum   = SUM_W'(as_ff) + SUM_W'(bc_ff) + ROUND_HALF;
      first_shift  = first_sum >>> COEF_FRAC;
      second_shift = second_sum >>> COEF_FRAC;
      first_in     = first_shift[COORD_W-1:0];
      second_in    = second_shift[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else if (rnd_ready) begin
         rnd_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rnd_ready && mul_valid_ff) begin
         first_ff     <= first_in;
         second_ff    <= second_in;
         rnd_carry_ff <= mul_carry_ff;
      end
   end

   assign out_valid  = rnd_valid_ff;
   assign out_first  = first_ff;
   assign out_second = second_ff;
   assign out_carry  = rnd_carry_ff;

endmodule

// File: src/pri_project.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_project
// Three-stage isometric projection: constant multiplies, truncation toward
// zero, then offset add, screen test and output clamp.
// ----------------------------------------------------------------------------
module pri_project (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pri_pkg::coord_type  in_x,
   input  pri_pkg::coord_type  in_y,
   input  pri_pkg::coord_type  in_z,
   input  pri_pkg::offset_type offset_x,
   input  pri_pkg::offset_type offset_y,
   output logic                out_valid,
   input  logic                out_ready,
   output pri_pkg::screen_type out_screen_x,
   output pri_pkg::screen_type out_screen_y,
   output logic                out_on_screen
);
   import pri_pkg::*;

   localparam logic signed [PRJ_W-1:0] TRUNC_BIAS = PRJ_W'(2 ** PROJ_FRAC - 1);
   localparam logic signed [POS_W-1:0] WIDTH_LIM  = POS_W'(SCREEN_WIDTH);
   localparam logic signed [POS_W-1:0] HEIGHT_LIM = POS_W'(SCREEN_HEIGHT);
   localparam logic signed [POS_W-1:0] CLAMP_HI   = POS_W'(OUT_MAX);
   localparam logic signed [POS_W-1:0] CLAMP_LO   = POS_W'(OUT_MIN);

   // Multiply stage
   logic                      mul_valid_ff, mul_ready;
   logic signed [DIFF_W-1:0]  diff_in, sum_in;
   logic signed [PPROD_W-1:0] px_in, pz_in, ps_in;
   logic signed [PPROD_W-1:0] px_ff, pz_ff, ps_ff;

   // Truncate stage
   logic                      trc_valid_ff, trc_ready;
   logic signed [PRJ_W-1:0]   px_full, py_full, px_biased, py_biased;
   logic signed [PRJ_W-1:0]   px_shift, py_shift;
   logic signed [Q_W-1:0]     qx_in, qy_in, qx_ff, qy_ff;

   // Output stage
   logic                      out_valid_ff, fin_ready;
   logic signed [POS_W-1:0]   col_in, row_in;
   screen_type                sx_in, sy_in, sx_ff, sy_ff;
   logic                      on_in, on_ff;

   assign mul_ready = ~mul_valid_ff | trc_ready;
   assign trc_ready = ~trc_valid_ff | fin_ready;
   assign fin_ready = ~out_valid_ff | out_ready;
   assign in_ready  = mul_ready;

   // Scale by the projection constants
   always_comb begin
      diff_in = DIFF_W'(in_x) - DIFF_W'(in_y);
      sum_in  = DIFF_W'(in_x) + DIFF_W'(in_y);
      px_in   = diff_in * K_HALF_SQRT2;
      pz_in   = in_z * K_SQRT_TWO_THIRDS;
      ps_in   = sum_in * K_INV_SQRT6;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         px_ff <= px_in;
         pz_ff <= pz_in;
         ps_ff <= ps_in;
      end
   end

   // Drop the Q30 fraction, rounding toward zero
   always_comb begin
      px_full   = PRJ_W'(px_ff);
      py_full   = PRJ_W'(pz_ff) - PRJ_W'(ps_ff);
      px_biased = px_full + (px_full[PRJ_W-1] ? TRUNC_BIAS : '0);
      py_biased = py_full + (py_full[PRJ_W-1] ? TRUNC_BIAS : '0);
      px_shift  = px_biased >>> PROJ_FRAC;
      py_shift  = py_biased >>> PROJ_FRAC;
      qx_in     = px_shift[Q_W-1:0];
      qy_in     = py_shift[Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trc_valid_ff <= 1'b0;
      end else if (trc_ready) begin
         trc_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (trc_ready && mul_valid_ff) begin
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
   end

   // Add the screen offset, test the bounds on the exact value, then clamp
   always_comb begin
      col_in = POS_W'(qx_ff) + POS_W'(offset_x);
      row_in = POS_W'(qy_ff) + POS_W'(offset_y);
      on_in  = !col_in[POS_W-1] && (col_in < WIDTH_LIM) &&
               !row_in[POS_W-1] && (row_in < HEIGHT_LIM);
      if (col_in > CLAMP_HI) begin
         sx_in = SCREEN_W'(OUT_MAX);
      end else if (col_in < CLAMP_LO) begin
         sx_in = SCREEN_W'(OUT_MIN);
      end else begin
         sx_in = col_in[SCREEN_W-1:0];
      end
      if (row_in > CLAMP_HI) begin
         sy_in = SCREEN_W'(OUT_MAX);
      end else if (row_in < CLAMP_LO) begin
         sy_in = SCREEN_W'(OUT_MIN);
      end else begin
         sy_in = row_in[SCREEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fin_ready) begin
         out_valid_ff <= trc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_ready && trc_valid_ff) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         on_ff <= on_in;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_screen_x  = sx_ff;
   assign out_screen_y  = sy_ff;
   assign out_on_screen = on_ff;

endmodule

// File: src/point_rotate_isometric_project.sv
`timescale 1ns / 1ps
// Structure: nine register stages between the request and rsp_valid
//   (three rotations of two stages each, then three projection stages).
// Throughput: one item per cycle while rsp_ready is high; a stage holds its item
//   only while the next is full and stalled, so bubbles close up when stalled.
// Reset: synchronous; clears every stage valid bit and loads the registers
//   with their reset coefficients and offsets.
// ----------------------------------------------------------------------------
// point_rotate_isometric_project
// Rotates a 3D point about Z, Y and X with configured Q2.14 coefficients,
// projects it isometrically onto the screen and flags whether it is visible.
// ----------------------------------------------------------------------------
module point_rotate_isometric_project (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pri_pkg::point_type             req_point_x,
   input  pri_pkg::point_type             req_point_y,
   input  pri_pkg::point_type             req_point_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pri_pkg::screen_type            rsp_screen_x,
   output pri_pkg::screen_type            rsp_screen_y,
   output logic                           rsp_on_screen,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pri_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [pri_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [pri_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import pri_pkg::*;

   localparam int PAD_W = COORD_W - POINT_W - COEF_FRAC;

   cfg_type   cfg;
   coord_type x0, y0, z0;

   logic      z_valid, z_ready, y_valid, y_ready, x_valid, x_ready;
   coord_type x1, y1, z1;
   coord_type x2, y2, z2;
   coord_type x3, y3, z3;

   pri_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Lift the integer point into Q14
   assign x0 = {{PAD_W{req_point_x[POINT_W-1]}}, req_point_x, {COEF_FRAC{1'b0}}};
   assign y0 = {{PAD_W{req_point_y[POINT_W-1]}}, req_point_y, {COEF_FRAC{1'b0}}};
   assign z0 = {{PAD_W{req_point_z[POINT_W-1]}}, req_point_z, {COEF_FRAC{1'b0}}};

   // About Z: (x, y) -> (x1, y1), z rides along
   pri_rotate u_rot_z (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_a       (x0),
      .in_b       (y0),
      .in_carry   (z0),
      .coef       (cfg.rot_z),
      .out_valid  (z_valid),
      .out_ready  (z_ready),
      .out_first  (x1),
      .out_second (y1),
      .out_carry  (z1)
   );

   // About Y: (z1, x1) -> (z2, x2), y rides along
   pri_rotate u_rot_y (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (z_valid),
      .in_ready   (z_ready),
      .in_a       (z1),
      .in_b       (x1),
      .in_carry   (y1),
      .coef       (cfg.rot_y),
      .out_valid  (y_valid),
      .out_ready  (y_ready),
      .out_first  (z2),
      .out_second (x2),
      .out_carry  (y2)
   );

   // About X: (y2, z2) -> (y3, z3), x rides along
   pri_rotate u_rot_x (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (y_valid),
      .in_ready   (y_ready),
      .in_a       (y2),
      .in_b       (z2),
      .in_carry   (x2),
      .coef       (cfg.rot_x),
      .out_valid  (x_valid),
      .out_ready  (x_ready),
      .out_first  (y3),
      .out_second (z3),
      .out_carry  (x3)
   );

   pri_project u_project (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (x_valid),
      .in_ready      (x_ready),
      .in_x          (x3),
      .in_y          (y3),
      .in_z          (z3),
      .offset_x      (cfg.offset_x),
      .offset_y      (cfg.offset_y),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_ready),
      .out_screen_x  (rsp_screen_x),
      .out_screen_y  (rsp_screen_y),
      .out_on_screen (rsp_on_screen)
   );

   // Input side stalls only when every stage is full and the output is held
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled while the pipeline can still move");

   // A visible point must lie inside the screen
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_screen) |->
         (!rsp_screen_x[SCREEN_W-1] && (rsp_screen_x < SCREEN_WIDTH) &&
          !rsp_screen_y[SCREEN_W-1] && (rsp_screen_y < SCREEN_HEIGHT)))
      else $error("on_screen set for a point outside the screen");

   // Registers come out of reset at their reset values and rsp_valid is low
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> ((cfg == CFG_RESET) && !rsp_valid))
      else $error("state after reset is wrong");

endmodule
